@@ hw/rtl/ssdw_pkg.sv @@
// ----------------------------------------------------------------------------
// ssdw_pkg
// Shared types, codes and saturation helpers for the driven-well integrator.
// ----------------------------------------------------------------------------
package ssdw_pkg;

    localparam int MAX_POINTS = 128;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = IDX_W + 1;

    // operation codes
    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_STEP    = 2'd1;
    localparam logic [1:0] OP_MEASURE = 2'd2;

    // register indexes
    localparam logic [2:0] REG_POINT_COUNT = 3'd0;
    localparam logic [2:0] REG_TIME_STEP   = 3'd1;
    localparam logic [2:0] REG_GRID_STEP   = 3'd2;
    localparam logic [2:0] REG_INV_STEP_SQ = 3'd3;
    localparam logic [2:0] REG_FIELD       = 3'd4;

    // right shift applied after a product
    typedef enum logic [1:0] {
        SH_1  = 2'd0,
        SH_28 = 2'd1,
        SH_32 = 2'd2,
        SH_33 = 2'd3
    } t_shift;

    typedef struct packed {
        logic              start;
        t_shift            sh;
        logic signed [47:0] a;
        logic signed [40:0] b;
    } t_mul_req;

    function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
        logic signed [47:0] r;
        if (v > 49'sd140737488355327)       r = 48'sh7FFFFFFFFFFF;
        else if (v < -49'sd140737488355328) r = 48'sh800000000000;
        else                                r = v[47:0];
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
        logic signed [31:0] r;
        if (v > 49'sd2147483647)       r = 32'sh7FFFFFFF;
        else if (v < -49'sd2147483648) r = 32'sh80000000;
        else                           r = v[31:0];
        return r;
    endfunction

endpackage

@@ hw/rtl/ssdw_mul.sv @@
// ----------------------------------------------------------------------------
// ssdw_mul
// Shared 48x41 signed multiplier: four 25x21 partial products, then
// saturation to +-(2^62-1), floor shift and clamp to 48 bits.
// ----------------------------------------------------------------------------
module ssdw_mul (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ssdw_pkg::t_mul_req    i_req,
    output logic signed [47:0]    o_res,
    output logic                  o_done
);

    localparam logic signed [88:0] PLIM = 89'sd4611686018427387903;

    logic signed [47:0] r_a;
    logic signed [40:0] r_b;
    ssdw_pkg::t_shift   r_sh;
    logic [1:0]         r_cnt;
    logic               r_busy, r_p1, r_p2, r_done;
    logic signed [88:0] r_acc;
    logic signed [62:0] r_sat;
    logic signed [47:0] r_res;

    logic signed [24:0] x;
    logic signed [20:0] y;
    logic signed [45:0] prod;
    logic signed [88:0] term;
    logic signed [62:0] shd;
    logic signed [88:0] n_acc;

    always_comb begin
        x = r_cnt[1] ? 25'($signed(r_a[47:24])) : $signed({1'b0, r_a[23:0]});
        y = r_cnt[0] ? $signed(r_b[40:20]) : $signed({1'b0, r_b[19:0]});
        prod = x * y;
        case (r_cnt)
            2'd0:    term = 89'(prod);
            2'd1:    term = 89'(prod) <<< 20;
            2'd2:    term = 89'(prod) <<< 24;
            default: term = 89'(prod) <<< 44;
        endcase
        n_acc = r_acc + term;
        case (r_sh)
            ssdw_pkg::SH_1:  shd = r_sat >>> 1;
            ssdw_pkg::SH_28: shd = r_sat >>> 28;
            ssdw_pkg::SH_32: shd = r_sat >>> 32;
            default:         shd = r_sat >>> 33;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_p1   <= 1'b0;
            r_p2   <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_a    <= i_req.a;
                r_b    <= i_req.b;
                r_sh   <= i_req.sh;
                r_acc  <= '0;
                r_cnt  <= 2'd0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_acc <= n_acc;
                r_cnt <= r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    r_busy <= 1'b0;
                    r_p1   <= 1'b1;
                end
            end
            if (r_p1) begin
                if (r_acc > PLIM)       r_sat <= PLIM[62:0];
                else if (r_acc < -PLIM) r_sat <= -PLIM[62:0];
                else                    r_sat <= r_acc[62:0];
                r_p1 <= 1'b0;
                r_p2 <= 1'b1;
            end
            if (r_p2) begin
                if (shd > 63'sd140737488355327)       r_res <= 48'sh7FFFFFFFFFFF;
                else if (shd < -63'sd140737488355328) r_res <= 48'sh800000000000;
                else                                  r_res <= shd[47:0];
                r_p2   <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_res  = r_res;
    assign o_done = r_done;

endmodule

@@ hw/rtl/schrodinger_split_step_driven_well_core.sv @@
// ----------------------------------------------------------------------------
// schrodinger_split_step_driven_well_core
// Fixed-point leapfrog integrator of a driven 1-D wave function with
// load, step and measure transactions.
// ----------------------------------------------------------------------------
//
//  channel   handshake            payload
//  -------   ------------------   -------------------------------------------
//  input     i_valid / o_ready    i_op, i_point_index, i_load_*, i_drive_*
//  result    o_valid / i_ready    o_norm, o_mean_position, o_energy
//  config    i_cfg_we             i_cfg_addr, i_cfg_wdata
//
//  Load: written straight into the sample stores. Step: 3 sweeps over the
//  n-2 interior points, 5 products each on the shared multiplier plus a
//  window fetch. Measure: 14 products for each of the n points.
//  o_ready is high only in idle. A finished measure parks until the output
//  register is free; the output register holds while i_ready is low.
//  Reset loads control and config defaults; the sample stores are not cleared.
//
module schrodinger_split_step_driven_well_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // config
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_addr,
    input  logic [31:0]        i_cfg_wdata,
    // input transaction
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_op,
    input  logic [6:0]         i_point_index,
    input  logic signed [31:0] i_load_real,
    input  logic signed [31:0] i_load_imag,
    input  logic signed [29:0] i_drive_now,
    input  logic signed [29:0] i_drive_half,
    input  logic signed [29:0] i_drive_full,
    // result transaction
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [47:0] o_norm,
    output logic signed [47:0] o_mean_position,
    output logic signed [47:0] o_energy
);

    localparam int IW = ssdw_pkg::IDX_W;
    localparam int CW = ssdw_pkg::CNT_W;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_START = 7'b0000010,
        S_FETCH = 7'b0000100,
        S_SHIFT = 7'b0001000,
        S_ISSUE = 7'b0010000,
        S_WAIT  = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state r_state;

    // configuration
    logic [7:0]         r_pc;
    logic [31:0]        r_dt, r_dx;
    logic [23:0]        r_iss;
    logic signed [31:0] r_k;

    // per-transaction context
    logic [CW-1:0]      r_n, r_i, r_fp;
    logic [1:0]         r_ph, r_pre;
    logic               r_meas;
    logic [3:0]         r_uc;
    logic [38:0]        r_xi;
    logic signed [29:0] r_drv0, r_drv1, r_drv2;

    // sample stores and neighbor windows
    logic signed [31:0] mem_re [ssdw_pkg::MAX_POINTS];
    logic signed [31:0] mem_im [ssdw_pkg::MAX_POINTS];
    logic signed [31:0] r_re_rd, r_im_rd;
    logic signed [31:0] r_re_m, r_re_c, r_re_p, r_im_m, r_im_c, r_im_p;

    // intermediates
    logic signed [47:0] r_kin, r_kin2, r_t1, r_t2, r_hr, r_hi;
    logic signed [47:0] r_m1, r_mag, r_tt, r_e;
    logic signed [47:0] r_nrm, r_mpos, r_en;

    // output register
    logic               r_ovalid;
    logic signed [47:0] r_onrm, r_ompos, r_oen;

    ssdw_pkg::t_mul_req mreq;
    logic signed [47:0] mres;
    logic               mdone;

    ssdw_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mreq),
        .o_res   (mres),
        .o_done  (mdone)
    );

    logic               accept;
    logic [CW-1:0]      n_clamped;
    logic signed [34:0] nlap_re, nlap_im;
    logic signed [39:0] pos, posq;
    logic signed [29:0] drive;
    logic signed [31:0] src_c, dst_c;
    logic signed [34:0] src_nlap;
    logic signed [48:0] kick_sum;
    logic               is_end, last_uc;
    logic [CW-1:0]      i_next, last_i;
    logic               re_we, im_we;
    logic [IW-1:0]      wr_addr;
    logic signed [31:0] wr_re, wr_im;
    logic signed [40:0] b_iss, b_dt, b_dx, b_xi;

    assign accept = i_valid && o_ready;

    always_comb begin
        if (r_pc < 8'd3)                           n_clamped = CW'(3);
        else if (r_pc > 8'(ssdw_pkg::MAX_POINTS))  n_clamped = CW'(ssdw_pkg::MAX_POINTS);
        else                                       n_clamped = CW'(r_pc);

        // negated three-point Laplacian, unscaled
        nlap_re = (35'(r_re_c) <<< 1) - 35'(r_re_p) - 35'(r_re_m);
        nlap_im = (35'(r_im_c) <<< 1) - 35'(r_im_p) - 35'(r_im_m);
        pos  = $signed({1'b0, r_xi}) - 40'sd2147483648;
        posq = pos >>> 4;

        case (r_ph)
            2'd0:    drive = r_drv0;
            2'd1:    drive = r_drv1;
            default: drive = r_drv2;
        endcase
        if (r_meas) drive = r_drv0;

        // the imaginary part is kicked by H of the real part and vice versa
        src_c    = (r_ph == 2'd1) ? r_re_c  : r_im_c;
        src_nlap = (r_ph == 2'd1) ? nlap_re : nlap_im;
        dst_c    = (r_ph == 2'd1) ? r_im_c  : r_re_c;
        kick_sum = (r_ph == 2'd1) ? 49'(dst_c) - 49'(mres) : 49'(dst_c) + 49'(mres);

        is_end  = (r_i == '0) || (r_i == r_n - CW'(1));
        last_uc = r_meas ? (r_uc == 4'd13) : (r_uc == 4'd4);
        i_next  = r_i + CW'(1);
        last_i  = r_meas ? r_n : r_n - CW'(1);

        b_iss = $signed({17'd0, r_iss});
        b_dt  = $signed({9'd0, r_dt});
        b_dx  = $signed({9'd0, r_dx});
        b_xi  = $signed({2'd0, r_xi});

        mreq.start = (r_state == S_ISSUE);
        mreq.sh    = ssdw_pkg::SH_28;
        mreq.a     = '0;
        mreq.b     = '0;
        if (r_meas) begin
            case (r_uc)
                4'd0: begin mreq.a = 48'(nlap_re); mreq.b = b_iss; mreq.sh = ssdw_pkg::SH_1; end
                4'd1: begin mreq.a = 48'(nlap_im); mreq.b = b_iss; mreq.sh = ssdw_pkg::SH_1; end
                4'd2: begin mreq.a = 48'(r_k);     mreq.b = 41'(posq);  end
                4'd3: begin mreq.a = r_t1;         mreq.b = 41'(drive); end
                4'd4: begin mreq.a = r_t2;         mreq.b = 41'(r_re_c); end
                4'd5: begin mreq.a = r_t2;         mreq.b = 41'(r_im_c); end
                4'd6: begin mreq.a = 48'(r_re_c);  mreq.b = 41'(r_re_c); end
                4'd7: begin mreq.a = 48'(r_im_c);  mreq.b = 41'(r_im_c); end
                4'd8: begin mreq.a = r_mag; mreq.b = b_xi; mreq.sh = ssdw_pkg::SH_32; end
                4'd9: begin mreq.a = r_hr;  mreq.b = 41'(r_re_c); end
                4'd10: begin mreq.a = r_hi; mreq.b = 41'(r_im_c); end
                4'd11: begin mreq.a = r_mag; mreq.b = b_dx; mreq.sh = ssdw_pkg::SH_32; end
                4'd12: begin mreq.a = r_tt;  mreq.b = b_dx; mreq.sh = ssdw_pkg::SH_32; end
                default: begin mreq.a = r_e; mreq.b = b_dx; mreq.sh = ssdw_pkg::SH_32; end
            endcase
        end else begin
            case (r_uc)
                4'd0: begin mreq.a = 48'(src_nlap); mreq.b = b_iss; mreq.sh = ssdw_pkg::SH_1; end
                4'd1: begin mreq.a = 48'(r_k);      mreq.b = 41'(posq);  end
                4'd2: begin mreq.a = r_t1;          mreq.b = 41'(drive); end
                4'd3: begin mreq.a = r_t2;          mreq.b = 41'(src_c); end
                default: begin
                    mreq.a  = r_hr;
                    mreq.b  = b_dt;
                    mreq.sh = (r_ph == 2'd1) ? ssdw_pkg::SH_32 : ssdw_pkg::SH_33;
                end
            endcase
        end

        // store write port: loads in idle, kick results during a step
        re_we   = 1'b0;
        im_we   = 1'b0;
        wr_addr = r_i[IW-1:0];
        wr_re   = ssdw_pkg::sat32(kick_sum);
        wr_im   = ssdw_pkg::sat32(kick_sum);
        if (r_state == S_IDLE) begin
            wr_addr = i_point_index;
            wr_re   = i_load_real;
            wr_im   = i_load_imag;
            re_we   = accept && (i_op == ssdw_pkg::OP_LOAD);
            im_we   = re_we;
        end else if (r_state == S_WAIT && mdone && !r_meas && last_uc) begin
            re_we = (r_ph != 2'd1);
            im_we = (r_ph == 2'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (re_we) mem_re[wr_addr] <= wr_re;
        if (im_we) mem_im[wr_addr] <= wr_im;
        if (r_state == S_FETCH) begin
            r_re_rd <= mem_re[r_fp[IW-1:0]];
            r_im_rd <= mem_im[r_fp[IW-1:0]];
        end
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc  <= 8'd101;
            r_dt  <= 32'd429497;
            r_dx  <= 32'd42949673;
            r_iss <= 24'd10000;
            r_k   <= 32'sd268435456;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                ssdw_pkg::REG_POINT_COUNT: r_pc  <= i_cfg_wdata[7:0];
                ssdw_pkg::REG_TIME_STEP:   r_dt  <= i_cfg_wdata;
                ssdw_pkg::REG_GRID_STEP:   r_dx  <= i_cfg_wdata;
                ssdw_pkg::REG_INV_STEP_SQ: r_iss <= i_cfg_wdata[23:0];
                ssdw_pkg::REG_FIELD:       r_k   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_meas   <= 1'b0;
            r_ph     <= 2'd0;
            r_uc     <= 4'd0;
            r_pre    <= 2'd0;
        end else begin
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_drv0 <= i_drive_now;
                        r_drv1 <= i_drive_half;
                        r_drv2 <= i_drive_full;
                        r_n    <= n_clamped;
                        r_ph   <= 2'd0;
                        r_nrm  <= '0;
                        r_mpos <= '0;
                        r_en   <= '0;
                        if (i_op == ssdw_pkg::OP_STEP) begin
                            r_meas  <= 1'b0;
                            r_state <= S_START;
                        end else if (i_op == ssdw_pkg::OP_MEASURE) begin
                            r_meas  <= 1'b1;
                            r_state <= S_START;
                        end
                    end
                end
                S_START: begin
                    // prime the windows: ends, then the first point
                    r_fp    <= '0;
                    r_pre   <= r_meas ? 2'd2 : 2'd3;
                    r_i     <= r_meas ? CW'(0) : CW'(1);
                    r_xi    <= r_meas ? 39'd0 : 39'(r_dx);
                    r_state <= S_FETCH;
                end
                S_FETCH: begin
                    r_fp    <= r_fp + CW'(1);
                    r_state <= S_SHIFT;
                end
                S_SHIFT: begin
                    r_re_m <= r_re_c;
                    r_re_c <= r_re_p;
                    r_re_p <= r_re_rd;
                    r_im_m <= r_im_c;
                    r_im_c <= r_im_p;
                    r_im_p <= r_im_rd;
                    if (r_pre > 2'd1) begin
                        r_pre   <= r_pre - 2'd1;
                        r_state <= S_FETCH;
                    end else begin
                        r_pre   <= 2'd0;
                        r_uc    <= 4'd0;
                        r_state <= S_ISSUE;
                    end
                end
                S_ISSUE: r_state <= S_WAIT;
                S_WAIT: begin
                    if (mdone) begin
                        if (r_meas) begin
                            case (r_uc)
                                4'd0:  r_kin  <= mres;
                                4'd1:  r_kin2 <= mres;
                                4'd2:  r_t1   <= mres;
                                4'd3:  r_t2   <= mres;
                                4'd4:  r_hr   <= is_end ? '0 :
                                                 ssdw_pkg::sat48(49'(r_kin) + 49'(mres));
                                4'd5:  r_hi   <= is_end ? '0 :
                                                 ssdw_pkg::sat48(49'(r_kin2) + 49'(mres));
                                4'd6:  r_m1   <= mres;
                                4'd7:  r_mag  <= ssdw_pkg::sat48(49'(r_m1) + 49'(mres));
                                4'd8:  r_tt   <= mres;
                                4'd9:  r_m1   <= mres;
                                4'd10: r_e    <= ssdw_pkg::sat48(49'(r_m1) + 49'(mres));
                                4'd11: r_nrm  <= ssdw_pkg::sat48(49'(r_nrm) + 49'(mres));
                                4'd12: r_mpos <= ssdw_pkg::sat48(49'(r_mpos) + 49'(mres));
                                default: r_en <= ssdw_pkg::sat48(49'(r_en) + 49'(mres));
                            endcase
                        end else begin
                            case (r_uc)
                                4'd0: r_kin <= mres;
                                4'd1: r_t1  <= mres;
                                4'd2: r_t2  <= mres;
                                4'd3: r_hr  <= ssdw_pkg::sat48(49'(r_kin) + 49'(mres));
                                default: ;  // kick written through the store port
                            endcase
                        end
                        if (!last_uc) begin
                            r_uc    <= r_uc + 4'd1;
                            r_state <= S_ISSUE;
                        end else begin
                            r_i  <= i_next;
                            r_xi <= r_xi + 39'(r_dx);
                            if (i_next != last_i) begin
                                r_state <= S_FETCH;
                            end else if (r_meas) begin
                                r_state <= S_DONE;
                            end else if (r_ph == 2'd2) begin
                                r_state <= S_IDLE;
                            end else begin
                                r_ph    <= r_ph + 2'd1;
                                r_state <= S_START;
                            end
                        end
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || i_ready) begin
                        r_onrm   <= r_nrm;
                        r_ompos  <= r_mpos;
                        r_oen    <= r_en;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = r_ovalid;
    assign o_norm          = r_onrm;
    assign o_mean_position = r_ompos;
    assign o_energy        = r_oen;

endmodule

@@ hw/rtl/ssdw_checker.sv @@
// ----------------------------------------------------------------------------
// ssdw_checker
// Port-level checks of the integrator core, bound to the top level.
// ----------------------------------------------------------------------------
module ssdw_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic [1:0]         i_op,
    input logic               o_valid,
    input logic               i_ready,
    input logic signed [47:0] o_norm,
    input logic signed [47:0] o_energy
);

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_norm) && $stable(o_energy))
        else $error("result changed while stalled");

    // a load completes in its own cycle
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_op == ssdw_pkg::OP_LOAD |=> o_ready)
        else $error("busy after load");

    // a step occupies the core and gives no result
    a_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_op == ssdw_pkg::OP_STEP && !o_valid |=> !o_ready && !o_valid)
        else $error("step transaction misbehaved");

    // a measure occupies the core
    a_meas: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_op == ssdw_pkg::OP_MEASURE |=> !o_ready)
        else $error("ready right after measure");

endmodule

bind schrodinger_split_step_driven_well_core ssdw_checker u_ssdw_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (i_valid),
    .o_ready  (o_ready),
    .i_op     (i_op),
    .o_valid  (o_valid),
    .i_ready  (i_ready),
    .o_norm   (o_norm),
    .o_energy (o_energy)
);

@@ sim/schrodinger_split_step_driven_well_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// schrodinger_split_step_driven_well_core_test
// Self-checking bench for the driven-well leapfrog integrator. Loads the whole
// sample grid, then runs directed and random load / step / measure traffic
// under several register settings. A bit-exact Q4.28 predictor in a small
// scoreboard class tracks the grid and checks every measure result.
// ----------------------------------------------------------------------------
module schrodinger_split_step_driven_well_core_test;

    localparam longint A48    = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint SMAX   = 64'sh0000_0000_7FFF_FFFF;
    localparam longint unsigned PLIM = 64'h3FFF_FFFF_FFFF_FFFF;
    localparam int     CYCLE_LIMIT = 10_000_000;
    localparam int     N_PHASES    = 20;

    typedef struct {
        longint norm;
        longint mean_pos;
        longint energy;
    } t_observables;

    // ------------------------------------------------------------------------
    // Predictor + result store. note_input() mirrors one accepted transaction,
    // check_result() compares one DUT result with the oldest expectation.
    // ------------------------------------------------------------------------
    class wave_predictor;
        longint psi_re[ssdw_pkg::MAX_POINTS], psi_im[ssdw_pkg::MAX_POINTS];
        longint h_re[ssdw_pkg::MAX_POINTS], h_im[ssdw_pkg::MAX_POINTS];
        longint unsigned n_reg, dt, dx, inv_dx2;
        longint k_field;
        t_observables pending[$];
        int mismatches;
        int n_load, n_step, n_meas;

        function new();
            n_reg = 101; dt = 429497; dx = 42949673; inv_dx2 = 10000;
            k_field = 268435456;
            for (int i = 0; i < ssdw_pkg::MAX_POINTS; i++) begin
                psi_re[i] = 0; psi_im[i] = 0; h_re[i] = 0; h_im[i] = 0;
            end
        endfunction

        function void set_reg(logic [2:0] addr, logic [31:0] data);
            case (addr)
                ssdw_pkg::REG_POINT_COUNT: n_reg = data[7:0];
                ssdw_pkg::REG_TIME_STEP:   dt = data;
                ssdw_pkg::REG_GRID_STEP:   dx = data;
                ssdw_pkg::REG_INV_STEP_SQ: inv_dx2 = data[23:0];
                ssdw_pkg::REG_FIELD:       k_field = longint'(signed'(data));
                default: ;
            endcase
        endfunction

        function int points();
            if (n_reg < 3) return 3;
            if (n_reg > ssdw_pkg::MAX_POINTS) return ssdw_pkg::MAX_POINTS;
            return int'(n_reg);
        endfunction

        function longint clamp(longint v, longint lim);
            if (v > lim) return lim;
            if (v < -lim - 1) return -lim - 1;
            return v;
        endfunction

        // exact product, magnitude saturated to 2^62-1
        function longint sat_mul(longint a, longint b);
            longint unsigned ua, ub, p;
            bit neg;
            ua = (a < 0) ? longint'(-a) : a;
            ub = (b < 0) ? longint'(-b) : b;
            neg = (a < 0) != (b < 0);
            if (ua != 0 && ub > PLIM / ua) p = PLIM;
            else p = ua * ub;
            return neg ? -longint'(p) : longint'(p);
        endfunction

        // floor shift (arithmetic) then 48-bit saturation
        function longint qmul(longint a, longint b, int s);
            return clamp(sat_mul(a, b) >>> s, A48);
        endfunction

        function longint ham_point(bit imag, int i, longint drv);
            longint pm, p0, pp, lap, kin, pos, t;
            pm = imag ? psi_im[i-1] : psi_re[i-1];
            p0 = imag ? psi_im[i]   : psi_re[i];
            pp = imag ? psi_im[i+1] : psi_re[i+1];
            lap = pp + pm - 2 * p0;
            kin = qmul(-lap, longint'(inv_dx2), 1);
            pos = longint'(i) * longint'(dx) - (64'sd1 <<< 31);
            t = qmul(k_field, pos >>> 4, 28);
            t = qmul(t, drv, 28);
            t = qmul(t, p0, 28);
            return clamp(kin + t, A48);
        endfunction

        // H psi with zeros at both ends
        function void build_ham(longint drv);
            int n;
            n = points();
            for (int i = 0; i < ssdw_pkg::MAX_POINTS; i++) begin
                h_re[i] = 0; h_im[i] = 0;
            end
            for (int i = 1; i + 1 < n; i++) begin
                h_re[i] = ham_point(1'b0, i, drv);
                h_im[i] = ham_point(1'b1, i, drv);
            end
        endfunction

        // real half kick from H im (shift 33), imaginary full kick from H re
        function void kick(bit imag, int s);
            longint d;
            for (int i = 0; i < points(); i++) begin
                if (!imag) begin
                    d = clamp(sat_mul(h_im[i], longint'(dt)) >>> s, A48);
                    psi_re[i] = clamp(psi_re[i] + d, SMAX);
                end else begin
                    d = clamp(sat_mul(h_re[i], longint'(dt)) >>> s, A48);
                    psi_im[i] = clamp(psi_im[i] - d, SMAX);
                end
            end
        endfunction

        function void note_input(logic [1:0] op, logic [6:0] idx,
                                 logic signed [31:0] lre, logic signed [31:0] lim,
                                 logic signed [29:0] dnow, logic signed [29:0] dhalf,
                                 logic signed [29:0] dfull);
            t_observables o;
            longint re, im, mag, e, xi;
            case (op)
                ssdw_pkg::OP_LOAD: begin
                    n_load++;
                    psi_re[idx] = longint'(lre);
                    psi_im[idx] = longint'(lim);
                end
                ssdw_pkg::OP_STEP: begin
                    n_step++;
                    build_ham(longint'(dnow));  kick(1'b0, 33);
                    build_ham(longint'(dhalf)); kick(1'b1, 32);
                    build_ham(longint'(dfull)); kick(1'b0, 33);
                end
                ssdw_pkg::OP_MEASURE: begin
                    n_meas++;
                    o.norm = 0; o.mean_pos = 0; o.energy = 0;
                    build_ham(longint'(dnow));
                    for (int i = 0; i < points(); i++) begin
                        re = psi_re[i]; im = psi_im[i];
                        mag = clamp(qmul(re, re, 28) + qmul(im, im, 28), A48);
                        xi = longint'(i) * longint'(dx);
                        e = clamp(qmul(re, h_re[i], 28) + qmul(im, h_im[i], 28), A48);
                        o.norm = clamp(o.norm + qmul(mag, longint'(dx), 32), A48);
                        o.mean_pos = clamp(o.mean_pos +
                                           qmul(qmul(mag, xi, 32), longint'(dx), 32), A48);
                        o.energy = clamp(o.energy + qmul(e, longint'(dx), 32), A48);
                    end
                    pending = {pending, o};
                end
                default: ;  // unused code: no effect
            endcase
        endfunction

        function void check_result(logic signed [47:0] nrm, logic signed [47:0] mp,
                                   logic signed [47:0] en);
            t_observables o;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result norm=%h pos=%h energy=%h",
                             nrm, mp, en);
                return;
            end
            o = pending.pop_front();
            if (longint'(nrm) != o.norm || longint'(mp) != o.mean_pos ||
                longint'(en) != o.energy) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR: result mismatch");
                    $display("  norm exp %h got %h", o.norm[47:0], nrm);
                    $display("  pos  exp %h got %h", o.mean_pos[47:0], mp);
                    $display("  en   exp %h got %h", o.energy[47:0], en);
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic               i_clk, i_rst_n;
    logic               i_cfg_we;
    logic [2:0]         i_cfg_addr;
    logic [31:0]        i_cfg_wdata;
    logic               i_valid, o_ready;
    logic [1:0]         i_op;
    logic [6:0]         i_point_index;
    logic signed [31:0] i_load_real, i_load_imag;
    logic signed [29:0] i_drive_now, i_drive_half, i_drive_full;
    logic               o_valid, i_ready;
    logic signed [47:0] o_norm, o_mean_position, o_energy;

    schrodinger_split_step_driven_well_core DUT (.*);

    wave_predictor model;
    bit            calm;       // no idling on either side while set
    int            cycles;
    int            n_settings;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    // result side: ready drops ~10% of cycles unless calm
    always @(negedge i_clk)
        i_ready <= calm ? 1'b1 : ($urandom_range(99) >= 10);

    always @(posedge i_clk)
        if (i_rst_n && o_valid && i_ready)
            model.check_result(o_norm, o_mean_position, o_energy);

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic write_reg(logic [2:0] addr, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_addr <= addr; i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        model.set_reg(addr, data);
    endtask

    // one input transaction, with a random pre-gap on the sender side
    task automatic send_transaction(logic [1:0] op, logic [6:0] idx,
                                    logic signed [31:0] lre, logic signed [31:0] lim,
                                    logic signed [29:0] dn, logic signed [29:0] dh,
                                    logic signed [29:0] df);
        if (!calm)
            while ($urandom_range(99) < 10) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
            end
        @(negedge i_clk);
        i_valid <= 1'b1; i_op <= op; i_point_index <= idx;
        i_load_real <= lre; i_load_imag <= lim;
        i_drive_now <= dn; i_drive_half <= dh; i_drive_full <= df;
        do @(posedge i_clk); while (!o_ready);
        model.note_input(op, idx, lre, lim, dn, dh, df);
    endtask

    // all results in, then room for a trailing step to finish
    task automatic settle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (model.pending.size() != 0) @(posedge i_clk);
        repeat (130 * model.points() + 60) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(3))
            0: return $urandom_range(0, 1 << 25) - (1 << 24);
            1: return $urandom_range(0, 1 << 29) - (1 << 28);
            2: return $urandom;
            default: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        endcase
    endfunction

    function automatic logic [29:0] rand_drive();
        // mostly a value in the sine range +-1.0, sometimes any 30-bit pattern
        if ($urandom_range(9) == 0) return 30'($urandom);
        return 30'($urandom_range(0, 1 << 29) - (1 << 28));
    endfunction

    task automatic rand_transaction();
        int r;
        logic [1:0] op;
        r = $urandom_range(99);
        if (r < 50)      op = ssdw_pkg::OP_LOAD;
        else if (r < 70) op = ssdw_pkg::OP_STEP;
        else if (r < 95) op = ssdw_pkg::OP_MEASURE;
        else             op = 2'd3;
        send_transaction(op, 7'($urandom_range(ssdw_pkg::MAX_POINTS - 1)),
                         rand_sample(), rand_sample(),
                         rand_drive(), rand_drive(), rand_drive());
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [31:0] pc, ts, gs, iq, fs;
        int n_items;

        model = new();
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_addr = '0; i_cfg_wdata = '0;
        i_valid = 1'b0; i_op = ssdw_pkg::OP_LOAD; i_point_index = '0;
        i_load_real = '0; i_load_imag = '0;
        i_drive_now = '0; i_drive_half = '0; i_drive_full = '0;
        i_ready = 1'b0; calm = 1'b0; cycles = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Stores are not cleared by reset: write every point before anything reads.
        for (int i = 0; i < ssdw_pkg::MAX_POINTS; i++)
            send_transaction(ssdw_pkg::OP_LOAD, 7'(i), rand_sample(), rand_sample(),
                             '0, '0, '0);

        // Directed: default registers, extreme samples and drives, unused op code.
        send_transaction(ssdw_pkg::OP_MEASURE, 0, 0, 0, 30'sd0, 30'sd0, 30'sd0);
        send_transaction(ssdw_pkg::OP_STEP, 0, 0, 0, 30'sd268435456, -30'sd268435456,
                         30'sd0);
        send_transaction(ssdw_pkg::OP_MEASURE, 0, 0, 0, -30'sd268435456, 0, 0);
        send_transaction(2'd3, 7'd5, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0);
        send_transaction(ssdw_pkg::OP_LOAD, 7'd0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0);
        send_transaction(ssdw_pkg::OP_LOAD, 7'd127, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0);
        send_transaction(ssdw_pkg::OP_LOAD, 7'd50, 32'h8000_0000, 32'h8000_0000, 0, 0, 0);
        send_transaction(ssdw_pkg::OP_LOAD, 7'd51, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0);
        send_transaction(ssdw_pkg::OP_MEASURE, 0, 0, 0, 30'h1FFF_FFFF, 0, 0);
        send_transaction(ssdw_pkg::OP_STEP, 0, 0, 0, 30'h1FFF_FFFF, 30'h2000_0000,
                         30'h3FFF_FFFF);
        send_transaction(ssdw_pkg::OP_MEASURE, 0, 0, 0, 30'h2000_0000, 0, 0);
        send_transaction(ssdw_pkg::OP_LOAD, 7'd50, 32'sd0, 32'sd0, 0, 0, 0);
        send_transaction(ssdw_pkg::OP_LOAD, 7'd51, 32'sd1, -32'sd1, 0, 0, 0);
        send_transaction(ssdw_pkg::OP_STEP, 0, 0, 0, 30'sd1000, -30'sd1000,
                         30'sd268435456);
        send_transaction(ssdw_pkg::OP_MEASURE, 0, 0, 0, 30'sd268435456, 0, 0);
        settle();

        // Random phases: fresh registers each time, extremes on some phases.
        for (int ph = 0; ph < N_PHASES; ph++) begin
            pc = $urandom_range(3, 16);
            ts = $urandom_range(0, 1 << 22);
            gs = $urandom;
            iq = $urandom_range(1, 40000);
            fs = $urandom;
            n_items = 58;
            case (ph)
                0: begin pc = 0;   ts = 32'hFFFF_FFFF; iq = 24'hFF_FFFF; end
                1: begin pc = 1;   gs = 0; fs = 32'h8000_0000; end
                2: begin pc = 2;   ts = 0; iq = 1; fs = 32'h7FFF_FFFF; end
                3: begin pc = 128; n_items = 6; end
                4: begin gs = 32'hFFFF_FFFF; fs = 0; end
                9: begin pc = 255; n_items = 5; end
                12: begin pc = 200; n_items = 0; end  // saturates to full grid
                13: begin pc = 3; ts = 32'hFFFF_FFFF; gs = 32'hFFFF_FFFF; end
                default: ;
            endcase
            calm = (ph == 6 || ph == 7);
            write_reg(ssdw_pkg::REG_POINT_COUNT, pc);
            write_reg(ssdw_pkg::REG_TIME_STEP, ts);
            write_reg(ssdw_pkg::REG_GRID_STEP, gs);
            write_reg(ssdw_pkg::REG_INV_STEP_SQ, iq);
            write_reg(ssdw_pkg::REG_FIELD, fs);
            n_settings++;
            for (int j = 0; j < n_items; j++)
                rand_transaction();
            settle();
        end

        $display("Covered %0d loads, %0d steps and %0d measures over %0d register settings",
                 model.n_load, model.n_step, model.n_meas, n_settings + 1);
        $display("Mismatches: %0d, results left over: %0d",
                 model.mismatches, model.pending.size());
        if (model.mismatches == 0 && model.pending.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
